/* rtl/core/msb_pkg.sv */
// msb_pkg: shared constants and types of the merge sort block.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package msb_pkg;

	localparam int unsigned BLOCK_SIZE_DEF = 64;
	localparam int unsigned VALUE_W        = 32;

	// one word handed along the cell row: a value and whether it is present
	typedef struct packed {
		logic                      valid;
		logic signed [VALUE_W-1:0] data;
	} msb_word_t;

	// per-cycle control broadcast from the sequencer to every cell
	typedef struct packed {
		logic shift;
	} msb_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/msb_in_if.sv */
// msb_in_if: input channel of the merge sort block (valid, ready, payload).
// Depends on msb_pkg for the value width.
`timescale 1ns / 1ps
`default_nettype none

interface msb_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [msb_pkg::VALUE_W-1:0] value;
	logic                              last_item;

	modport source (output valid, output value, output last_item, input ready);
	modport sink   (input valid, input value, input last_item, output ready);
endinterface

`default_nettype wire

/* rtl/core/msb_out_if.sv */
// msb_out_if: result channel of the merge sort block (valid, ready, payload).
// Depends on msb_pkg for the value width.
`timescale 1ns / 1ps
`default_nettype none

interface msb_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [msb_pkg::VALUE_W-1:0] sorted_value;
	logic                              last_result;
	logic                              overflow;

	modport source (output valid, output sorted_value, output last_result,
		output overflow, input ready);
	modport sink   (input valid, input sorted_value, input last_result,
		input overflow, output ready);
endinterface

`default_nettype wire

/* rtl/core/msb_cell.sv */
// msb_cell: one cell of the sorting row; keeps the smaller value, passes the larger on.
// Depends on msb_pkg (msb_word_t, msb_ctrl_t).
`timescale 1ns / 1ps
`default_nettype none

module msb_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire msb_pkg::msb_ctrl_t ctrl,
	input  wire msb_pkg::msb_word_t carry_in,
	input  wire msb_pkg::msb_word_t nb_held,
	output msb_pkg::msb_word_t      held,
	output msb_pkg::msb_word_t      carry_out
);

	logic                               occ_q;
	logic signed [msb_pkg::VALUE_W-1:0] val_q;
	logic                               cv_q;
	logic signed [msb_pkg::VALUE_W-1:0] cdata_q;
	logic                               keep_new;

	// strictly greater held value yields to the newcomer; equal keeps the earlier one
	assign keep_new = $signed(val_q) > $signed(carry_in.data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			cv_q  <= 1'b0;
		end else if (ctrl.shift) begin
			occ_q <= nb_held.valid;
			cv_q  <= 1'b0;
		end else if (carry_in.valid) begin
			occ_q <= 1'b1;
			cv_q  <= occ_q;
		end else begin
			cv_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q <= nb_held.data;
		end else if (carry_in.valid) begin
			if (!occ_q) begin
				val_q <= carry_in.data;
			end else if (keep_new) begin
				val_q   <= carry_in.data;
				cdata_q <= val_q;
			end else begin
				cdata_q <= carry_in.data;
			end
		end
	end

	assign held      = '{valid: occ_q, data: val_q};
	assign carry_out = '{valid: cv_q, data: cdata_q};

endmodule

`default_nettype wire

/* rtl/core/merge_sort_block.sv */
// merge_sort_block: top level; sequencer, result register and the row of sort cells.
// Depends on msb_pkg, msb_in_if, msb_out_if and msb_cell.
//
// Usage
//   in_ch  : transfers of {value, last_item}. Each transfer offers one signed value;
//            last_item marks the final value of a block and starts the sort.
//   out_ch : transfers of {sorted_value, last_result, overflow}, ascending signed
//            order, last_result on the final value, overflow on every result of a
//            block in which a value was dropped.
// Timing
//   Loading accepts one value per cycle: each value enters a row of BLOCK_SIZE cells
//   and ripples right one cell a cycle until it finds its place (insertion row).
//   A block holds at most BLOCK_SIZE values; further values are dropped and flagged.
//   After the last value the row settles for the longest ripple, then results
//   leave at one per cycle while out_ch takes them, by shifting the row toward cell 0.
//   in_ch.ready is high only while loading; the final result may still wait in
//   the result register while the next block loads.
// Reset and stall
//   arst_n clears the cell occupancy, the counters and the result valid flag.
//   A stalled out_ch holds its result; the row stops shifting until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module merge_sort_block #(
	parameter int unsigned BLOCK_SIZE = msb_pkg::BLOCK_SIZE_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	msb_in_if.sink    in_ch,
	msb_out_if.source out_ch
);

	localparam int unsigned CW = $clog2(BLOCK_SIZE + 1);

	localparam logic [1:0] ST_LOAD   = 2'd0;
	localparam logic [1:0] ST_SETTLE = 2'd1;
	localparam logic [1:0] ST_OUT    = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] settle_q;
	logic [CW-1:0] rem_q;
	logic          ovf_q;
	logic          ovf_blk_q;

	logic                               out_valid_q;
	logic signed [msb_pkg::VALUE_W-1:0] out_value_q;
	logic                               out_last_q;
	logic                               out_ovf_q;

	logic          in_xfer;
	logic          full;
	logic          pop;
	logic [CW-1:0] count_next;

	msb_pkg::msb_ctrl_t ctrl;
	msb_pkg::msb_word_t carry [BLOCK_SIZE+1];
	msb_pkg::msb_word_t held  [BLOCK_SIZE+1];

	assign in_ch.ready = (state_q == ST_LOAD);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign full        = (count_q == CW'(BLOCK_SIZE));
	assign count_next  = full ? count_q : count_q + CW'(1);

	// pop the head cell into the result register when it is free or being emptied
	assign pop        = (state_q == ST_OUT) && (rem_q != '0) && (!out_valid_q || out_ch.ready);
	assign ctrl.shift = pop;

	// insertion point at the left end of the row; drop the value when full
	assign carry[0]          = '{valid: in_xfer && !full, data: in_ch.value};
	assign held[BLOCK_SIZE]  = '{valid: 1'b0, data: '0};

	for (genvar i = 0; i < BLOCK_SIZE; i++) begin : g_cell
		msb_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.carry_in  (carry[i]),
			.nb_held   (held[i+1]),
			.held      (held[i]),
			.carry_out (carry[i+1])
		);
	end

	// sequencer: load, let the row settle, then drain it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			settle_q  <= '0;
			rem_q     <= '0;
			ovf_q     <= 1'b0;
			ovf_blk_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (in_ch.last_item) begin
							state_q   <= ST_SETTLE;
							rem_q     <= count_next;
							settle_q  <= CW'(BLOCK_SIZE);
							ovf_blk_q <= ovf_q || full;
							count_q   <= '0;
							ovf_q     <= 1'b0;
						end else begin
							count_q <= count_next;
							ovf_q   <= ovf_q || full;
						end
					end
				end
				ST_SETTLE: begin
					settle_q <= settle_q - CW'(1);
					if (settle_q == CW'(1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (pop) begin
						rem_q <= rem_q - CW'(1);
						if (rem_q == CW'(1)) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// result register: hold while stalled, advance on pop, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_value_q <= held[0].data;
			out_last_q  <= (rem_q == CW'(1));
			out_ovf_q   <= ovf_blk_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.sorted_value = out_value_q;
	assign out_ch.last_result  = out_last_q;
	assign out_ch.overflow     = out_ovf_q;

endmodule

`default_nettype wire

/* rtl/core/msb_checker.sv */
// msb_checker: port-level assertions on merge_sort_block, attached by bind.
// Depends on merge_sort_block and its channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module msb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        in_last,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] out_value,
	input wire logic        out_last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
		else $error("stalled result changed");

	// the last value of a block closes the input until the block is drained
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input still open after last item");

	// more results of the block follow, so the input stays closed
	a_mid_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("input open in the middle of a block's results");

	// no result while reset is applied
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind merge_sort_block msb_checker u_msb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_last   (in_ch.last_item),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_value (out_ch.sorted_value),
	.out_last  (out_ch.last_result)
);

`default_nettype wire

/* dv/tb_merge_sort_block.sv */
// tb_merge_sort_block: self-checking testbench of merge_sort_block.
// Depends on msb_pkg, msb_in_if, msb_out_if and the block's RTL.
// Keeps a running sorted copy of each block and checks each result transfer against it.
`timescale 1ns / 1ps

module tb_merge_sort_block;

	localparam int unsigned BLOCK_SIZE = msb_pkg::BLOCK_SIZE_DEF;
	// settle time of the cell row plus a full block draining, with margin
	localparam int unsigned DRAIN_CYCLES = 2 * BLOCK_SIZE + 16;
	localparam int unsigned PHASE_ITEMS = 100;

	// idling patterns, one per phase of the random part
	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef logic signed [msb_pkg::VALUE_W-1:0] word_t;

	// one expected result transfer
	typedef struct packed {
		word_t sorted_value;
		logic  last_result;
		logic  overflow;
	} sorted_res_t;

	// one row of the directed table; exp_value is used only where typed is set
	typedef struct {
		word_t value;
		bit    last_item;
		bit    typed;
		word_t exp_value;
	} stim_row_t;

	localparam int unsigned DIRECTED_ROWS = 20;

	logic clk;
	logic arst_n;

	msb_in_if  in_ch();
	msb_out_if out_ch();

	merge_sort_block #(
		.BLOCK_SIZE(BLOCK_SIZE)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Single-value blocks have their result typed in; all other rows go through
	// the running sort below.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000},
		'{32'sh7FFF_FFFF, 1'b1, 1'b1, 32'sh7FFF_FFFF},
		'{32'sh0000_0000, 1'b1, 1'b1, 32'sh0000_0000},
		'{32'shFFFF_FFFF, 1'b1, 1'b1, 32'shFFFF_FFFF},
		// mixed signs, both extremes and a repeated value
		'{32'sh0000_0005, 1'b0, 1'b0, 32'sh0},
		'{32'shFFFF_FFFB, 1'b0, 1'b0, 32'sh0},
		'{32'sh7FFF_FFFF, 1'b0, 1'b0, 32'sh0},
		'{32'sh8000_0000, 1'b0, 1'b0, 32'sh0},
		'{32'sh0000_0000, 1'b0, 1'b0, 32'sh0},
		'{32'shFFFF_FFFF, 1'b0, 1'b0, 32'sh0},
		'{32'sh0000_0005, 1'b1, 1'b0, 32'sh0},
		// held in descending order
		'{32'sh0000_0028, 1'b0, 1'b0, 32'sh0},
		'{32'sh0000_001E, 1'b0, 1'b0, 32'sh0},
		'{32'shFFFF_FFEC, 1'b0, 1'b0, 32'sh0},
		'{32'shFFFF_FFE2, 1'b1, 1'b0, 32'sh0},
		// all values equal
		'{32'sh1234_5678, 1'b0, 1'b0, 32'sh0},
		'{32'sh1234_5678, 1'b0, 1'b0, 32'sh0},
		'{32'sh1234_5678, 1'b1, 1'b0, 32'sh0},
		// alternating bit patterns, already descending as signed values
		'{32'sh5555_5555, 1'b0, 1'b0, 32'sh0},
		'{32'shAAAA_AAAA, 1'b1, 1'b0, 32'sh0}
	};

	// running state of the sort: the values held in this block, kept in order
	word_t       held_sorted[$];
	bit          block_dropped;
	sorted_res_t expected_sorted[$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned error_count;
	int unsigned items_sent;
	int unsigned blocks_sent;
	int unsigned overflow_blocks;
	int unsigned results_seen;
	sorted_res_t got_res;
	sorted_res_t want_res;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Insert the transferred value after any equal ones (stable order), or
	// drop it when full. On the last item, queue the whole sorted block
	// as expected results if queue_results is set, and clear for the next block.
	task automatic sort_transfer(input word_t v, input bit last, input bit queue_results);
		int pos;
		sorted_res_t r;
		if (held_sorted.size() < BLOCK_SIZE) begin
			pos = held_sorted.size();
			while (pos > 0 && held_sorted[pos-1] > v)
				pos--;
			held_sorted.insert(pos, v);
		end else begin
			block_dropped = 1'b1;
		end
		if (last) begin
			if (queue_results) begin
				foreach (held_sorted[i]) begin
					r.sorted_value = held_sorted[i];
					r.last_result  = (i == held_sorted.size() - 1);
					r.overflow     = block_dropped;
					expected_sorted.push_back(r);
				end
			end
			if (block_dropped)
				overflow_blocks++;
			blocks_sent++;
			held_sorted.delete();
			block_dropped = 1'b0;
		end
	endtask

	// Offer one value, idling beforehand at random, and hold it until the
	// transfer. Valid stays high into the next item unless a gap follows.
	task automatic send_value(input word_t v, input bit last, input bit queue_results);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid     <= 1'b0;
			in_ch.value     <= word_t'($urandom);
			in_ch.last_item <= 1'($urandom);
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.value     <= v;
		in_ch.last_item <= last;
		do
			@(posedge clk);
		while (!in_ch.ready);
		items_sent++;
		sort_transfer(v, last, queue_results);
	endtask

	// Mostly full-range values; some extremes and some narrow ranges so that
	// repeats turn up within a block.
	function automatic word_t pick_value();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0) begin
			case ($urandom_range(3))
				0:       return 32'sh8000_0000;
				1:       return 32'sh7FFF_FFFF;
				2:       return 32'sh0000_0000;
				default: return 32'shFFFF_FFFF;
			endcase
		end
		if (r <= 3)
			return word_t'($signed($urandom_range(15)) - 8);
		return word_t'($urandom);
	endfunction

	task automatic send_block(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			send_value(pick_value(), (i == n - 1), 1'b1);
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct  = 66;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct  = 0;
				recv_stall_pct = 66;
			end
			default: begin
				send_idle_pct  = 10;
				recv_stall_pct = 10;
			end
		endcase
	endtask

	// Receiver: drop ready at random according to the current phase.
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check every result transfer against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			got_res.sorted_value = out_ch.sorted_value;
			got_res.last_result  = out_ch.last_result;
			got_res.overflow     = out_ch.overflow;
			if (expected_sorted.size() == 0) begin
				$display("%0t: unexpected result: sorted_value %0d last_result %0b overflow %0b",
					$time, got_res.sorted_value, got_res.last_result, got_res.overflow);
				error_count++;
			end else begin
				want_res = expected_sorted.pop_front();
				if (got_res.sorted_value !== want_res.sorted_value) begin
					$display("%0t: sorted_value mismatch: expected %0d actual %0d",
						$time, want_res.sorted_value, got_res.sorted_value);
					error_count++;
				end
				if (got_res.last_result !== want_res.last_result) begin
					$display("%0t: last_result mismatch: expected %0b actual %0b",
						$time, want_res.last_result, got_res.last_result);
					error_count++;
				end
				if (got_res.overflow !== want_res.overflow) begin
					$display("%0t: overflow mismatch: expected %0b actual %0b",
						$time, want_res.overflow, got_res.overflow);
					error_count++;
				end
			end
		end
	end

	// Stimulus: reset, directed table, then four phases of random blocks.
	initial begin
		int unsigned phase_items;
		int unsigned n;
		sorted_res_t typed_res;

		error_count     = 0;
		items_sent      = 0;
		blocks_sent     = 0;
		overflow_blocks = 0;
		results_seen    = 0;
		block_dropped   = 1'b0;
		set_idling(IDLE_NONE);

		arst_n          <= 1'b0;
		in_ch.valid     <= 1'b0;
		in_ch.value     <= '0;
		in_ch.last_item <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; typed rows queue their result before the
		// transfer, ahead of which nothing of their block is pending.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].typed) begin
				typed_res.sorted_value = directed_rows[i].exp_value;
				typed_res.last_result  = 1'b1;
				typed_res.overflow     = 1'b0;
				expected_sorted.push_back(typed_res);
			end
			send_value(directed_rows[i].value, directed_rows[i].last_item,
				!directed_rows[i].typed);
		end

		// Each phase opens with one large block around the store size: one
		// short of full, exactly full, last item dropped, two values dropped.
		// Small blocks fill the rest of the phase.
		for (int p = 0; p < 4; p++) begin
			set_idling(idle_mode_t'(p));
			n = BLOCK_SIZE - 1 + p;
			send_block(n);
			phase_items = n;
			while (phase_items < PHASE_ITEMS) begin
				if ($urandom_range(99) < 85)
					n = $urandom_range(8, 1);
				else
					n = $urandom_range(32, 9);
				send_block(n);
				phase_items += n;
			end
		end

		in_ch.valid <= 1'b0;
		while (expected_sorted.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d values in %0d blocks (%0d with dropped values).",
			items_sent, blocks_sent, overflow_blocks);
		$display("Checked %0d sorted results under four idling patterns.", results_seen);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Hard limit, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("Timeout: %0d results still expected", expected_sorted.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/msb_pkg.sv
rtl/core/msb_in_if.sv
rtl/core/msb_out_if.sv
rtl/core/msb_cell.sv
rtl/core/merge_sort_block.sv
rtl/core/msb_checker.sv
dv/tb_merge_sort_block.sv
